// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL; compiled out when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every rising clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an expression is never true outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== design/bplru_pkg.sv =====
package bplru_pkg;

	localparam int DEF_WAYS        = 4;
	localparam int DEF_INDEX_BITS  = 6;
	localparam int DEF_OFFSET_BITS = 5;

	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 32;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 136;

	// Counter slots: hit/miss crossed with instruction/data
	localparam logic [1:0] CNT_INST_HIT  = 2'd0;
	localparam logic [1:0] CNT_DATA_HIT  = 2'd1;
	localparam logic [1:0] CNT_INST_MISS = 2'd2;
	localparam logic [1:0] CNT_DATA_MISS = 2'd3;

	typedef struct packed {
		logic clear_step;
		logic capture;
		logic commit;
	} bplru_cmd_t;

	typedef struct packed {
		logic clear_last;
	} bplru_status_t;

endpackage

// ===== design/bplru_ram.sv =====
module bplru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/bplru_ctrl.sv =====
module bplru_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	input  bplru_pkg::bplru_status_t status,
	output bplru_pkg::bplru_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.clear_step = (state_q == ST_CLEAR);
		cmd.capture    = s_tvalid && s_tready;
		// Retire only when the output register is free or being drained
		cmd.commit     = (state_q == ST_LOOK) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/bplru_dp.sv =====
module bplru_dp #(
	parameter int WAYS        = bplru_pkg::DEF_WAYS,
	parameter int INDEX_BITS  = bplru_pkg::DEF_INDEX_BITS,
	parameter int OFFSET_BITS = bplru_pkg::DEF_OFFSET_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bplru_pkg::bplru_cmd_t               cmd,
	output bplru_pkg::bplru_status_t            status,
	input  logic [bplru_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tuser,
	output logic [bplru_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int TAG_W = bplru_pkg::ADDR_W - OFFSET_BITS - INDEX_BITS;
	localparam int SETS  = 1 << INDEX_BITS;
	localparam int WAY_W = $clog2(WAYS);
	localparam int CW    = bplru_pkg::CNT_W;
	localparam int PAD_W = bplru_pkg::M_TDATA_W - 4 * CW - 4;

	// Captured access
	logic [INDEX_BITS-1:0] idx_q;
	logic [TAG_W-1:0]      tag_q;
	logic                  wr_q;
	logic                  data_q;
	logic [INDEX_BITS-1:0] clr_q;

	logic [WAYS*TAG_W-1:0] tag_row;
	logic [WAYS*TAG_W-1:0] tag_row_n;
	logic [3*WAYS-1:0]     stat_row;
	logic [3*WAYS-1:0]     stat_row_n;
	logic [3*WAYS-1:0]     stat_wdata;
	logic [INDEX_BITS-1:0] stat_waddr;

	logic [WAYS-1:0] valid, dirty, mru, match, used_oh;
	logic [WAYS-1:0] valid_n, dirty_n, mru_or, mru_n, wr_oh;
	logic [WAY_W-1:0] hit_way, inv_way, clr_way, used;
	logic [WAY_W+1:0] used_ext;
	logic hit, evict;
	logic [1:0] cnt_sel;

	logic [CW-1:0] cnt_q [4];
	logic [CW-1:0] cnt_n [4];

	logic       hit_q, evict_q;
	logic [1:0] way_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= s_tdata[OFFSET_BITS +: INDEX_BITS];
			tag_q  <= s_tdata[bplru_pkg::ADDR_W-1 -: TAG_W];
			wr_q   <= s_tdata[bplru_pkg::ADDR_W];
			data_q <= s_tuser;
		end
	end

	// Sweep the status rows after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign status.clear_last = &clr_q;

	bplru_ram #(
		.WIDTH (WAYS * TAG_W),
		.DEPTH (SETS)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (cmd.commit && !hit),
		.wr_addr (idx_q),
		.wr_data (tag_row_n),
		.rd_en   (cmd.capture),
		.rd_addr (s_tdata[OFFSET_BITS +: INDEX_BITS]),
		.rd_data (tag_row)
	);

	assign stat_waddr = cmd.clear_step ? clr_q : idx_q;
	assign stat_wdata = cmd.clear_step ? '0 : stat_row_n;

	bplru_ram #(
		.WIDTH (3 * WAYS),
		.DEPTH (SETS)
	) u_stat_ram (
		.clk     (clk),
		.wr_en   (cmd.commit || cmd.clear_step),
		.wr_addr (stat_waddr),
		.wr_data (stat_wdata),
		.rd_en   (cmd.capture),
		.rd_addr (s_tdata[OFFSET_BITS +: INDEX_BITS]),
		.rd_data (stat_row)
	);

	assign valid = stat_row[WAYS-1:0];
	assign dirty = stat_row[2*WAYS-1:WAYS];
	assign mru   = stat_row[3*WAYS-1:2*WAYS];

	always_comb begin
		hit_way = '0;
		inv_way = '0;
		clr_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = valid[w] && (tag_row[w*TAG_W +: TAG_W] == tag_q);
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (!valid[w]) begin
				inv_way = WAY_W'(w);
			end
			if (!mru[w]) begin
				clr_way = WAY_W'(w);
			end
		end
		hit = |match;
		priority if (hit) begin
			used = hit_way;
		end else if (!(&valid)) begin
			used = inv_way;
		end else if (!(&mru)) begin
			used = clr_way;
		end else begin
			used = '0;
		end
	end

	always_comb begin
		used_oh = {{(WAYS-1){1'b0}}, 1'b1} << used;
		wr_oh   = wr_q ? used_oh : '0;
		valid_n = valid | used_oh;
		dirty_n = hit ? (dirty | wr_oh) : ((dirty & ~used_oh) | wr_oh);
		mru_or  = mru | used_oh;
		mru_n   = (&mru_or) ? used_oh : mru_or;
		evict   = !hit && |(valid & dirty & used_oh);
		stat_row_n = {mru_n, dirty_n, valid_n};
		for (int w = 0; w < WAYS; w++) begin
			tag_row_n[w*TAG_W +: TAG_W] = used_oh[w] ? tag_q : tag_row[w*TAG_W +: TAG_W];
		end
		used_ext = {2'b00, used};
	end

	always_comb begin
		if (hit) begin
			cnt_sel = data_q ? bplru_pkg::CNT_DATA_HIT : bplru_pkg::CNT_INST_HIT;
		end else begin
			cnt_sel = data_q ? bplru_pkg::CNT_DATA_MISS : bplru_pkg::CNT_INST_MISS;
		end
		for (int i = 0; i < 4; i++) begin
			// Saturate at all ones
			if ((cnt_sel == 2'(i)) && !(&cnt_q[i])) begin
				cnt_n[i] = cnt_q[i] + 1'b1;
			end else begin
				cnt_n[i] = cnt_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= cnt_n[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q   <= hit;
			way_q   <= used_ext[1:0];
			evict_q <= evict;
		end
	end

	// Counters move only on commit, so they hold while a result waits
	assign m_tdata = {{PAD_W{1'b0}},
		cnt_q[bplru_pkg::CNT_DATA_MISS], cnt_q[bplru_pkg::CNT_INST_MISS],
		cnt_q[bplru_pkg::CNT_DATA_HIT], cnt_q[bplru_pkg::CNT_INST_HIT],
		evict_q, way_q, hit_q};

endmodule

// ===== design/bit_plru_cache_lookup.sv =====
// A result beat is registered when its access retires; retirement waits while an
// earlier result is unaccepted. No access is taken until the last one retires; the
// set's tag and status rows are read on accept and written back on retirement via
// the single-row RAMs. Reset: arst_n clears control and counters, then a sweep of
// all sets zeroes valid, dirty and MRU rows with s_tready low; tags stay undefined.
`include "assert_macros.svh"

module bit_plru_cache_lookup #(
	parameter int WAYS        = bplru_pkg::DEF_WAYS,
	parameter int INDEX_BITS  = bplru_pkg::DEF_INDEX_BITS,
	parameter int OFFSET_BITS = bplru_pkg::DEF_OFFSET_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Access beat
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] address, [32] opcode, [39:33] zero
	input  logic [bplru_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] access_kind
	input  logic                            s_tuser,
	// Result beat
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] hit, [2:1] way_used, [3] evicted_dirty, [35:4] inst_hit_count,
	// [67:36] data_hit_count, [99:68] inst_miss_count,
	// [131:100] data_miss_count, [135:132] zero
	output logic [bplru_pkg::M_TDATA_W-1:0] m_tdata
);

	bplru_pkg::bplru_cmd_t    cmd;
	bplru_pkg::bplru_status_t status;

	// Sequence clearing, lookup and retirement; own the result valid
	bplru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Tag compare across all ways in parallel, victim pick, MRU update, counters
	bplru_dp #(
		.WAYS        (WAYS),
		.INDEX_BITS  (INDEX_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata)
	);

	// Never take a new access in the cycle that retires one: the row write would race the read
	`ASSERT_NEVER(a_no_accept_on_commit, clk, arst_n, s_tready && cmd.commit, "accept during commit")
	// Hold off accesses while the status rows are being swept
	`ASSERT_NEVER(a_no_accept_in_clear, clk, arst_n, s_tready && cmd.clear_step, "accept during clear")
	// A retired access always shows up as a result beat
	`ASSERT_PROP(a_commit_shows, clk, arst_n, cmd.commit |=> m_tvalid, "commit lost")
	// A result beat only appears after a retirement
	`ASSERT_PROP(a_valid_from_commit, clk, arst_n, $rose(m_tvalid) |-> $past(cmd.commit), "spurious result")

endmodule
